### rtl/core/tcp_pkg.sv
// Types and constants for the typed cooldown timer pool.
// Shared by the slot cell and the top level; depends on nothing.
package tcp_pkg;

	localparam logic [7:0] TYPE_NONE = 8'd0;

	// request codes
	localparam logic [2:0] REQ_ADD    = 3'd0;
	localparam logic [2:0] REQ_CHECK  = 3'd1;
	localparam logic [2:0] REQ_LOOKUP = 3'd2;
	localparam logic [2:0] REQ_RESET  = 3'd3;
	localparam logic [2:0] REQ_TICK   = 3'd4;
	localparam logic [2:0] REQ_CLEAR  = 3'd5;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WRITE,
		ST_DONE
	} state_t;

	// one slot record as it travels along the ring
	typedef struct packed {
		logic        used;
		logic [7:0]  ev;
		logic [15:0] dur;
		logic [15:0] elap;
		logic        complete;
		logic        recycle;
		logic        notify;
	} rec_t;

endpackage

### rtl/core/typed_cooldown_timer_pool.sv
// Top level of the typed cooldown timer pool: request control, output
// register and a ring of tcp_cell slots. Depends on tcp_pkg and tcp_cell.
//
// channel | dir | fields
// s_*     | in  | tuser: req_type; tdata: event_type, duration, recycle, notify_on_end
// m_*     | out | tuser: expired; tdata: ok, slot, running; tlast: last
//
// One request at a time. The slot records rotate one cell per cycle through
// the ring unless a tick stalls, with the slot at the head cell handled each
// cycle, so a pass visits every slot once. Add makes two passes (scan, then
// write), every other request one pass; a tick stalls while an expiry word
// waits at a blocked output, and the closing word waits for the output
// register to empty.
// Reset clears all slots at once; no clearing pass.
module typed_cooldown_timer_pool #(
	parameter int SLOTS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // event_type[7:0], duration[23:8], recycle[24], notify_on_end[25]
	input  logic [2:0]  s_tuser,   // req_type[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // ok[0], slot[4:1], running[5]
	output logic        m_tuser,   // expired[0]
	output logic        m_tlast
);

	localparam int IW = (SLOTS > 2) ? $clog2(SLOTS) : 1;
	localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

	tcp_pkg::state_t state_q, state_d;

	logic [2:0]  req_q;
	logic [7:0]  ev_q;
	logic [15:0] dur_q;
	logic        rec_q;
	logic        ntf_q;

	logic [IW-1:0] idx_q;
	logic          found_q, fcomp_q, free_q;
	logic [IW-1:0] fidx_q, freeidx_q;

	tcp_pkg::rec_t ring [SLOTS];
	tcp_pkg::rec_t head, nr;

	logic emit, stall, advance, add_go, out_load;
	logic [3:0] slot4, fslot4, freeslot4;
	logic       o_ok, o_running, o_expired, o_last;
	logic [3:0] o_slot;
	logic       m_tvalid_q, m_tuser_q, m_tlast_q;
	logic [7:0] m_tdata_q;

	assign head = ring[0];
	assign s_tready = (state_q == tcp_pkg::ST_IDLE);

	assign slot4     = 4'(32'(idx_q));
	assign fslot4    = 4'(32'(fidx_q));
	assign freeslot4 = 4'(32'(freeidx_q));

	assign add_go = (ev_q != tcp_pkg::TYPE_NONE) && !(found_q && !fcomp_q) && free_q;

	// work on the record at the head cell
	always_comb begin
		nr = head;
		emit = 1'b0;
		if (state_q == tcp_pkg::ST_SCAN) begin
			case (req_q)
				tcp_pkg::REQ_RESET: begin
					if (head.used && head.ev == ev_q) begin
						nr.complete = 1'b0;
						nr.elap     = 16'd0;
					end
				end
				tcp_pkg::REQ_TICK: begin
					if (head.used && head.ev != tcp_pkg::TYPE_NONE) begin
						if (head.complete && !head.recycle) begin
							nr = '0;
						end else if (head.elap >= head.dur) begin
							nr.complete = 1'b1;
							nr.elap     = 16'd0;
							emit        = head.notify;
						end else if (!head.complete) begin
							nr.elap = head.elap + 16'd1;
						end
					end
				end
				tcp_pkg::REQ_CLEAR: nr = '0;
				default: ;
			endcase
		end else if (state_q == tcp_pkg::ST_WRITE) begin
			if (add_go && idx_q == freeidx_q) begin
				nr = '{used: 1'b1, ev: ev_q, dur: dur_q, elap: 16'd0,
					complete: 1'b0, recycle: rec_q, notify: ntf_q};
			end
		end
	end

	assign stall   = emit && m_tvalid_q && !m_tready;
	assign advance = ((state_q == tcp_pkg::ST_SCAN) || (state_q == tcp_pkg::ST_WRITE)) && !stall;

	// ring of slot cells, shifting toward the head
	for (genvar g = 0; g < SLOTS; g++) begin : g_cell
		tcp_pkg::rec_t cd;
		if (g == SLOTS - 1) begin : g_tail
			assign cd = nr;
		end else begin : g_mid
			assign cd = ring[g+1];
		end
		tcp_cell u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.shift (advance),
			.d     (cd),
			.q     (ring[g])
		);
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tcp_pkg::ST_IDLE: if (s_tvalid) state_d = tcp_pkg::ST_SCAN;
			tcp_pkg::ST_SCAN: begin
				if (advance && idx_q == LAST_IDX)
					state_d = (req_q == tcp_pkg::REQ_ADD) ? tcp_pkg::ST_WRITE
						: tcp_pkg::ST_DONE;
			end
			tcp_pkg::ST_WRITE: if (advance && idx_q == LAST_IDX) state_d = tcp_pkg::ST_DONE;
			tcp_pkg::ST_DONE: if (!m_tvalid_q || m_tready) state_d = tcp_pkg::ST_IDLE;
			default: state_d = tcp_pkg::ST_IDLE;
		endcase
	end

	// result word
	always_comb begin
		o_ok = 1'b0; o_slot = 4'd0; o_running = 1'b0; o_expired = 1'b0; o_last = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			tcp_pkg::ST_SCAN: begin
				if (emit && !stall) begin
					out_load  = 1'b1;
					o_slot    = slot4;
					o_expired = 1'b1;
				end
			end
			tcp_pkg::ST_DONE: begin
				out_load = !m_tvalid_q || m_tready;
				o_last   = 1'b1;
				case (req_q)
					tcp_pkg::REQ_ADD: begin
						o_ok   = add_go;
						o_slot = add_go ? freeslot4 : 4'd0;
					end
					tcp_pkg::REQ_CHECK: begin
						o_ok      = found_q;
						o_slot    = found_q ? fslot4 : 4'd0;
						o_running = found_q && !fcomp_q;
					end
					tcp_pkg::REQ_LOOKUP: begin
						o_ok   = found_q;
						o_slot = found_q ? fslot4 : 4'd0;
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= tcp_pkg::ST_IDLE;
			idx_q      <= '0;
			found_q    <= 1'b0;
			free_q     <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (s_tvalid && s_tready) begin
				idx_q   <= '0;
				found_q <= 1'b0;
				free_q  <= 1'b0;
			end else if (advance) begin
				idx_q <= (idx_q == LAST_IDX) ? '0 : idx_q + 1'b1;
				if (state_q == tcp_pkg::ST_SCAN) begin
					if (head.used && head.ev == ev_q && !found_q) found_q <= 1'b1;
					if (!head.used && !free_q) free_q <= 1'b1;
				end
			end
			if (out_load) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
		end
	end

	// request and scan payload
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			req_q <= s_tuser;
			ev_q  <= s_tdata[7:0];
			dur_q <= s_tdata[23:8];
			rec_q <= s_tdata[24];
			ntf_q <= s_tdata[25];
		end
		if (advance && state_q == tcp_pkg::ST_SCAN) begin
			if (head.used && head.ev == ev_q && !found_q) begin
				fidx_q  <= idx_q;
				fcomp_q <= head.complete;
			end
			if (!head.used && !free_q) freeidx_q <= idx_q;
		end
		if (out_load) begin
			m_tdata_q <= {2'b00, o_running, o_slot, o_ok};
			m_tuser_q <= o_expired;
			m_tlast_q <= o_last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

`ifndef ASSERT_OFF
	a_idle_idx: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == tcp_pkg::ST_IDLE |-> idx_q == '0)
		else $error("slot ring not aligned while idle");
	a_write_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tcp_pkg::ST_WRITE && add_go && idx_q == freeidx_q) |-> !head.used)
		else $error("add overwrote a used slot");
	a_notice_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> !m_tlast)
		else $error("expiry notice marked last");
`endif

endmodule

### rtl/core/tcp_cell.sv
// One slot cell of the timer pool ring: holds a slot record and takes its
// neighbor's record on every shift. Depends on tcp_pkg.
module tcp_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          shift,
	input  tcp_pkg::rec_t d,
	output tcp_pkg::rec_t q
);

	logic        used_q;
	logic [7:0]  ev_q;
	logic [15:0] dur_q;
	logic [15:0] elap_q;
	logic        complete_q;
	logic        recycle_q;
	logic        notify_q;

	// control fields clear on reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q     <= 1'b0;
			ev_q       <= tcp_pkg::TYPE_NONE;
			elap_q     <= 16'd0;
			complete_q <= 1'b0;
			recycle_q  <= 1'b0;
			notify_q   <= 1'b0;
		end else if (shift) begin
			used_q     <= d.used;
			ev_q       <= d.ev;
			elap_q     <= d.elap;
			complete_q <= d.complete;
			recycle_q  <= d.recycle;
			notify_q   <= d.notify;
		end
	end

	// duration is only read after an add wrote it
	always_ff @(posedge clk) begin
		if (shift) begin
			dur_q <= d.dur;
		end
	end

	assign q = '{used: used_q, ev: ev_q, dur: dur_q, elap: elap_q,
		complete: complete_q, recycle: recycle_q, notify: notify_q};

endmodule
